/* hw/rtl/uee_pkg.sv */
package uee_pkg;

  // Event counter width; counters wrap at this width
  localparam int CountWidth = 32;

  // Width of the range channel write payload in bytes
  localparam logic [7:0] RangeWriteBytes = 8'd2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_LINE  = 2'd1,
    REQ_TIME  = 2'd2
  } req_code_t;

  // Configuration register indexes
  localparam logic [7:0] RegModelAttached = 8'd0;
  localparam logic [7:0] RegRangeChannel  = 8'd1;
  localparam logic [7:0] RegTriggerLine   = 8'd2;
  localparam logic [7:0] RegStartDelay    = 8'd3;
  localparam logic [7:0] RegUsPerMm       = 8'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  channel_num;
    logic [7:0]  byte_count;
    logic [7:0]  data_high;
    logic [7:0]  data_low;
    logic [7:0]  line_num;
    logic        line_level;
    logic [63:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic        write_accepted;
    logic        echo_changed;
    logic        echo_level;
    logic        wake_valid;
    logic [63:0] wake_time_us;
    logic        trigger_dropped;
    logic [31:0] pulse_total;
    logic [31:0] ignored_total;
    logic [15:0] range_now_mm;
  } out_item_t;

endpackage

/* hw/rtl/uee_in_if.sv */
interface uee_in_if;
  import uee_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/uee_out_if.sv */
interface uee_out_if;
  import uee_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/uee_cfg_if.sv */
interface uee_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* hw/rtl/ultrasonic_echo_emulator.sv */
// An item passes through the input register and then the result register
// before its result is offered.
// Throughput: one item per cycle while rsp is not stalled; the state update
// for an item is combinational, so back-to-back items see each other's state.
// Reset (rst, synchronous): registers take their listed reset values, the
// measurement returns to idle, counters and range clear, both stages empty.
module ultrasonic_echo_emulator (
  input logic       clk,
  input logic       rst,
  uee_cfg_if.sink   cfg,
  uee_in_if.sink    req,
  uee_out_if.source rsp
);
  import uee_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_ECHO = 2'd2
  } phase_t;

  // Configuration registers
  logic        model_attached;
  logic [7:0]  range_channel_id;
  logic [7:0]  trigger_line_id;
  logic [15:0] start_delay_us;
  logic [7:0]  us_per_mm;

  // Emulator state
  logic [15:0]           distance_mm, distance_mm_next;
  phase_t                phase, phase_next;
  logic [63:0]           due_time, due_time_next;
  logic [CountWidth-1:0] pulse_counter, pulse_counter_next;
  logic [CountWidth-1:0] ignored_counter, ignored_counter_next;
  logic                  echo_state, echo_state_next;

  // Pipeline registers
  logic      stage_valid;
  in_item_t  stage;
  logic      rsp_valid;
  out_item_t rsp_data;
  out_item_t result;
  logic      advance;
  logic [23:0] echo_len;

  // Move the staged item to the result register when the slot is free
  assign advance   = stage_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign echo_len = distance_mm * us_per_mm;

  // Compute next state and result for the staged item
  always_comb begin
    distance_mm_next     = distance_mm;
    phase_next           = phase;
    due_time_next        = due_time;
    pulse_counter_next   = pulse_counter;
    ignored_counter_next = ignored_counter;
    echo_state_next      = echo_state;
    result               = '0;

    case (stage.req_type)
      REQ_WRITE: begin
        if (stage.channel_num == range_channel_id && stage.byte_count == RangeWriteBytes) begin
          distance_mm_next      = {stage.data_high, stage.data_low};
          result.write_accepted = 1'b1;
        end
      end
      REQ_LINE: begin
        if (stage.line_num == trigger_line_id && stage.line_level && model_attached) begin
          if (phase != PH_IDLE) begin
            ignored_counter_next   = ignored_counter + 1'b1;
            result.trigger_dropped = 1'b1;
          end else begin
            pulse_counter_next  = pulse_counter + 1'b1;
            phase_next          = PH_WAIT;
            due_time_next       = stage.now_us + 64'(start_delay_us);
            result.wake_valid   = 1'b1;
            result.wake_time_us = due_time_next;
          end
        end
      end
      REQ_TIME: begin
        if (phase != PH_IDLE && stage.now_us >= due_time && model_attached) begin
          result.echo_changed = 1'b1;
          if (phase == PH_WAIT) begin
            phase_next          = PH_ECHO;
            echo_state_next     = 1'b1;
            due_time_next       = stage.now_us + 64'(echo_len);
            result.wake_valid   = 1'b1;
            result.wake_time_us = due_time_next;
          end else begin
            phase_next      = PH_IDLE;
            echo_state_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    result.echo_level    = echo_state_next;
    result.pulse_total   = 32'(pulse_counter_next);
    result.ignored_total = 32'(ignored_counter_next);
    result.range_now_mm  = distance_mm_next;
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      model_attached   <= 1'b1;
      range_channel_id <= 8'd0;
      trigger_line_id  <= 8'd0;
      start_delay_us   <= 16'd0;
      us_per_mm        <= 8'd6;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegModelAttached: model_attached   <= cfg.wdata[0];
        RegRangeChannel:  range_channel_id <= cfg.wdata[7:0];
        RegTriggerLine:   trigger_line_id  <= cfg.wdata[7:0];
        RegStartDelay:    start_delay_us   <= cfg.wdata;
        RegUsPerMm:       us_per_mm        <= cfg.wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Advance emulator state on each item leaving the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mm     <= '0;
      phase           <= PH_IDLE;
      due_time        <= '0;
      pulse_counter   <= '0;
      ignored_counter <= '0;
      echo_state      <= 1'b0;
    end else if (advance) begin
      distance_mm     <= distance_mm_next;
      phase           <= phase_next;
      due_time        <= due_time_next;
      pulse_counter   <= pulse_counter_next;
      ignored_counter <= ignored_counter_next;
      echo_state      <= echo_state_next;
    end
  end

  // Input stage: capture each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.ready) begin
      stage_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stage <= req.data;
    end
  end

  // Result stage: hold until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= result;
    end
  end

endmodule

/* tb/ultrasonic_echo_emulator_test.sv */
`timescale 1ns / 1ps

module ultrasonic_echo_emulator_test;
  import uee_pkg::*;

  localparam int StallLimit = 5000;
  localparam int LongHold = 400;
  localparam int MaxReported = 10;

  // Request code that the block does not define
  localparam logic [1:0] ReqUnused = 2'd3;
  // Register index past the last register
  localparam logic [7:0] RegSpare = 8'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_ECHO = 2'd2
  } meas_phase_t;

  logic clk;
  logic rst;

  uee_cfg_if cfg_bus ();
  uee_in_if req_bus ();
  uee_out_if rsp_bus ();

  ultrasonic_echo_emulator DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  // Register copies used by the ranger model and the sequence builder
  logic        cfg_attached;
  logic [7:0]  cfg_range_chan;
  logic [7:0]  cfg_trig_line;
  logic [15:0] cfg_start_delay;
  logic [7:0]  cfg_us_per_mm;

  // Ranger model state
  logic [15:0]           range_mm;
  meas_phase_t           meas_phase;
  logic [63:0]           due_us;
  logic [CountWidth-1:0] pulse_cnt;
  logic [CountWidth-1:0] ignored_cnt;
  logic                  echo_high;

  in_item_t  item_queue[$];
  out_item_t report_queue[$];

  int queued_total = 0;
  int checked_total = 0;
  int mismatches = 0;
  int stuck_cycles = 0;
  int src_gap = 0;
  int sink_stall = 0;
  bit long_hold_done = 0;
  bit calm = 0;

  // Sequence builder state
  logic [63:0] clock_us = 64'd0;
  logic [15:0] gen_range_mm = 16'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the ranger by one request and return the report it produces
  function automatic out_item_t emulate_item(input in_item_t it);
    out_item_t r;
    r = '0;
    case (req_code_t'(it.req_type))
      REQ_WRITE: begin
        if (it.channel_num == cfg_range_chan && it.byte_count == RangeWriteBytes) begin
          range_mm = {it.data_high, it.data_low};
          r.write_accepted = 1'b1;
        end
      end
      REQ_LINE: begin
        if (it.line_num == cfg_trig_line && it.line_level && cfg_attached) begin
          if (meas_phase != PH_IDLE) begin
            ignored_cnt = ignored_cnt + 1'b1;
            r.trigger_dropped = 1'b1;
          end else begin
            pulse_cnt = pulse_cnt + 1'b1;
            meas_phase = PH_WAIT;
            due_us = it.now_us + 64'(cfg_start_delay);
            r.wake_valid = 1'b1;
            r.wake_time_us = due_us;
          end
        end
      end
      REQ_TIME: begin
        if (meas_phase != PH_IDLE && it.now_us >= due_us && cfg_attached) begin
          r.echo_changed = 1'b1;
          if (meas_phase == PH_WAIT) begin
            meas_phase = PH_ECHO;
            echo_high = 1'b1;
            due_us = it.now_us + 64'(range_mm) * 64'(cfg_us_per_mm);
            r.wake_valid = 1'b1;
            r.wake_time_us = due_us;
          end else begin
            meas_phase = PH_IDLE;
            echo_high = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.echo_level = echo_high;
    r.pulse_total = 32'(pulse_cnt);
    r.ignored_total = 32'(ignored_cnt);
    r.range_now_mm = range_mm;
    return r;
  endfunction

  function automatic string fmt_report(input out_item_t r);
    return $sformatf("acc=%b chg=%b echo=%b wake=%b@%h drop=%b pulses=%0d ignored=%0d range=%0d",
                     r.write_accepted, r.echo_changed, r.echo_level, r.wake_valid,
                     r.wake_time_us, r.trigger_dropped, r.pulse_total, r.ignored_total,
                     r.range_now_mm);
  endfunction

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (report_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("unexpected report: %s", fmt_report(got));
    end else begin
      want = report_queue.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("report %0d expected: %s", checked_total, fmt_report(want));
          $display("report %0d actual:   %s", checked_total, fmt_report(got));
        end
      end
    end
  endtask

  // Offer queued requests, predict each one as it transfers
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      req_bus.data <= '0;
      src_gap = 0;
      range_mm = '0;
      meas_phase = PH_IDLE;
      due_us = '0;
      pulse_cnt = '0;
      ignored_cnt = '0;
      echo_high = 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        report_queue.push_back(emulate_item(req_bus.data));
      if (!req_bus.valid || req_bus.ready) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          req_bus.data <= item_queue.pop_front();
          req_bus.valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0)
            src_gap = $urandom_range(1, 16);
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Take reports, stall at random, hold off once long enough to back up the input
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        check_report(rsp_bus.data);
        checked_total++;
      end
      if (!long_hold_done && item_queue.size() > 200) begin
        sink_stall = LongHold;
        long_hold_done = 1'b1;
      end
      if (sink_stall > 0) begin
        sink_stall = sink_stall - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0)
          sink_stall = $urandom_range(1, 16);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    cfg_bus.valid <= 1'b0;
    case (idx)
      RegModelAttached: cfg_attached = val[0];
      RegRangeChannel:  cfg_range_chan = val[7:0];
      RegTriggerLine:   cfg_trig_line = val[7:0];
      RegStartDelay:    cfg_start_delay = val;
      RegUsPerMm:       cfg_us_per_mm = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] attached, input logic [15:0] chan,
                            input logic [15:0] line, input logic [15:0] delay,
                            input logic [15:0] per_mm);
    write_reg(RegModelAttached, attached);
    write_reg(RegRangeChannel, chan);
    write_reg(RegTriggerLine, line);
    write_reg(RegStartDelay, delay);
    write_reg(RegUsPerMm, per_mm);
  endtask

  // Wait until every queued request has come back as a report
  task automatic drain();
    while (checked_total < queued_total) @(posedge clk);
  endtask

  task automatic enqueue(input in_item_t it);
    item_queue.push_back(it);
    queued_total++;
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.req_type = 2'($urandom_range(0, 3));
    it.channel_num = 8'($urandom);
    it.byte_count = 8'($urandom);
    it.data_high = 8'($urandom);
    it.data_low = 8'($urandom);
    it.line_num = 8'($urandom);
    it.line_level = 1'($urandom);
    it.now_us = {$urandom, $urandom};
    return it;
  endfunction

  task automatic push_write(input logic [7:0] chan, input logic [7:0] len,
                            input logic [15:0] mm);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_WRITE;
    it.channel_num = chan;
    it.byte_count = len;
    {it.data_high, it.data_low} = mm;
    enqueue(it);
  endtask

  task automatic push_line(input logic [7:0] line, input logic level,
                           input logic [63:0] at_us);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_LINE;
    it.line_num = line;
    it.line_level = level;
    it.now_us = at_us;
    enqueue(it);
  endtask

  task automatic push_advance(input logic [63:0] at_us);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_TIME;
    it.now_us = at_us;
    enqueue(it);
  endtask

  // Build one trigger / echo rise / echo fall cycle with random timing around the edges
  task automatic push_measurement();
    logic [15:0] mm;
    logic [63:0] t_rise;
    logic [63:0] t_fall;
    if ($urandom_range(0, 9) == 0)
      clock_us = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      mm = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
      push_write(cfg_range_chan, RangeWriteBytes, mm);
      gen_range_mm = mm;
    end
    push_line(cfg_trig_line, 1'b1, clock_us);
    if ($urandom_range(0, 3) == 0)
      push_line(cfg_trig_line, 1'b1, clock_us + 64'd1);
    if ($urandom_range(0, 3) == 0)
      push_line(cfg_trig_line, 1'b0, clock_us + 64'd1);
    t_rise = clock_us + 64'(cfg_start_delay);
    if (cfg_start_delay != 16'd0 && $urandom_range(0, 1) == 1)
      push_advance(t_rise - 64'd1);
    if ($urandom_range(0, 2) == 0)
      t_rise = t_rise + 64'($urandom_range(1, 5));
    push_advance(t_rise);
    t_fall = t_rise + 64'(gen_range_mm) * 64'(cfg_us_per_mm);
    if ($urandom_range(0, 3) == 0)
      push_line(cfg_trig_line, 1'b1, t_rise + 64'd1);
    if (t_fall != t_rise && $urandom_range(0, 1) == 1)
      push_advance(t_fall - 64'd1);
    push_advance(t_fall + 64'($urandom_range(0, 3)));
    clock_us = t_fall + 64'($urandom_range(4, 100));
  endtask

  // Mostly well-formed measurement cycles, some random noise, then wait for all reports
  task automatic random_phase(input int n_items);
    int start;
    int noise;
    int k;
    start = queued_total;
    noise = 0;
    while (queued_total - start - noise < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        push_measurement();
      end else begin
        k = $urandom_range(1, 3);
        noise = noise + k;
        repeat (k) enqueue(noise_item());
      end
    end
    drain();
  endtask

  initial begin
    in_item_t it;

    // Hold reset and the configuration bus at known values from time zero
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.wdata = '0;

    cfg_attached = 1'b1;
    cfg_range_chan = 8'd0;
    cfg_trig_line = 8'd0;
    cfg_start_delay = 16'd0;
    cfg_us_per_mm = 8'd6;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset register values
    push_write(8'd0, RangeWriteBytes, 16'h0102);
    push_write(8'd1, RangeWriteBytes, 16'hFFFF);
    push_write(8'd0, 8'd3, 16'hFFFF);
    push_write(8'd0, 8'd255, 16'h00FF);
    push_write(8'd0, 8'd0, 16'hFF00);
    push_write(8'd0, RangeWriteBytes, 16'hFFFF);
    push_write(8'd0, RangeWriteBytes, 16'h0003);
    push_line(8'd0, 1'b0, 64'd50);
    push_line(8'd255, 1'b1, 64'd60);
    push_advance(64'd100);
    push_line(8'd0, 1'b1, 64'd1000);
    push_line(8'd0, 1'b1, 64'd1001);
    push_advance(64'd999);
    push_advance(64'd1000);
    push_line(8'd0, 1'b1, 64'd1005);
    push_advance(64'd1017);
    push_advance(64'd1018);
    it = noise_item();
    it.req_type = ReqUnused;
    enqueue(it);
    // Trigger at the last representable time so the fall time wraps past zero
    push_line(8'd0, 1'b1, '1);
    push_advance('1);
    push_advance(64'd17);
    push_advance(64'd0);
    // Zero range: echo rises and falls at the same time
    push_write(8'd0, RangeWriteBytes, 16'h0000);
    push_line(8'd0, 1'b1, 64'd5);
    push_advance(64'd5);
    push_advance(64'd5);
    drain();

    // Zero delay and zero width per millimetre
    set_config(16'd1, 16'h005A, 16'h00A5, 16'd0, 16'd0);
    random_phase(300);

    // Largest delay, width, channel and line
    set_config(16'd1, 16'h00FF, 16'h00FF, 16'hFFFF, 16'h00FF);
    random_phase(300);

    // Raw 16-bit writes so unused upper bits must be dropped
    write_reg(RegSpare, 16'($urandom));
    set_config(16'($urandom) | 16'd1, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
    random_phase(300);

    // Detached: triggers and time are ignored, writes still land
    set_config(16'd0, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
               16'($urandom_range(0, 100)), 16'($urandom_range(0, 255)));
    random_phase(60);

    // Last part without idling on either side
    calm = 1'b1;
    set_config(16'd1, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
               16'($urandom_range(0, 2000)), 16'($urandom_range(0, 20)));
    random_phase(300);

    repeat (10) @(posedge clk);
    if (report_queue.size() != 0) begin
      mismatches++;
      $display("%0d expected reports never arrived", report_queue.size());
    end
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
